[rtl/cau_pkg.sv]
// cau_pkg: types, constants and opcode names for the complex arithmetic unit
// used by every module of the unit; depends on nothing

package cau_pkg;

  localparam int unsigned FracBits = 16;
  // one restoring step per quotient bit of (num << FracBits) / den
  localparam int unsigned DivSteps = 64 + FracBits;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef struct packed {
    cau_op_e            opcode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    logic               overflow;
  } cau_out_t;

  // classified item as it sits in the queue
  typedef struct packed {
    cau_op_e            op;
    logic               dz;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cau_qstat_t;

endpackage

[rtl/cau_front.sv]
// cau_front: input register that takes transfers and classifies each item
// depends on cau_pkg; feeds cau_queue

module cau_front import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cau_in_t    in_data_i,
  output logic       push_o,
  output cau_item_t  push_data_o,
  input  cau_qstat_t qstat_i
);

  logic      valid_q;
  cau_item_t item_q, item_d;
  logic      accept;

  assign in_stall_o = valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !qstat_i.full;
  assign push_data_o = item_q;

  always_comb begin
    item_d.op   = in_data_i.opcode;
    item_d.a_re = in_data_i.a_re;
    item_d.a_im = in_data_i.a_im;
    item_d.b_re = in_data_i.b_re;
    item_d.b_im = in_data_i.b_im;
    // divide by zero only when both parts of the divisor are zero
    item_d.dz   = (in_data_i.opcode == OP_DIV) && (in_data_i.b_re == '0) &&
                  (in_data_i.b_im == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/cau_queue.sv]
// cau_queue: short queue between the front and the arithmetic back end
// depends on cau_pkg

module cau_queue import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cau_item_t  push_data_i,
  input  logic       pop_i,
  output cau_item_t  pop_data_o,
  output cau_qstat_t qstat_o
);

  cau_item_t         mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]    cnt_q;

  assign qstat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign pop_data_o    = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(logic [QPtrW-1:0] p);
    if (p == QPtrW'(QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/cau_back.sv]
// cau_back: multiplier stage, combine stage, pipelined restoring dividers
// and saturating output register; depends on cau_pkg, fed by cau_queue

module cau_back import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cau_qstat_t qstat_i,
  input  cau_item_t  pop_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cau_out_t   out_data_o
);

  typedef struct packed {
    logic        neg;
    logic [63:0] num;
    logic [63:0] rem;
    logic [32:0] q;
    logic        big;
  } lane_t;

  typedef struct packed {
    logic               is_div;
    logic               dz;
    logic signed [64:0] alt_re;
    logic signed [64:0] alt_im;
    logic [63:0]        den;
    lane_t              re;
    lane_t              im;
  } stage_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  localparam logic signed [64:0] SatHi = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0] SatLo = 65'sh1_FFFF_FFFF_8000_0000;

  logic en;

  // multiplier stage
  logic               m_valid_q;
  cau_item_t          m_item_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;

  // combine stage is entry 0, each divider step adds one entry
  logic [DivSteps:0] st_valid_q;
  stage_t            st_q [DivSteps+1];
  stage_t            c_d;

  logic     out_valid_q;
  cau_out_t out_q, out_d;

  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && !qstat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic lane_t lane_init(logic signed [64:0] n);
    lane_t l;
    l.neg = n[64];
    l.num = n[64] ? 64'(-n) : n[63:0];
    l.rem = '0;
    l.q   = '0;
    l.big = 1'b0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [63:0] d);
    logic [64:0] r;
    logic        ge;
    lane_t       o;
    r     = {l.rem, l.num[63]};
    ge    = (r >= {1'b0, d});
    o     = l;
    o.num = {l.num[62:0], 1'b0};
    o.rem = ge ? 64'(r - {1'b0, d}) : r[63:0];
    o.big = l.big | l.q[32];
    o.q   = {l.q[31:0], ge};
    return o;
  endfunction

  function automatic stage_t stage_step(stage_t s);
    stage_t o;
    o    = s;
    o.re = lane_step(s.re, s.den);
    o.im = lane_step(s.im, s.den);
    return o;
  endfunction

  function automatic sat_t sat_div(lane_t l);
    sat_t s;
    s.ovf = 1'b0;
    s.val = l.q[31:0];
    if (l.big || l.q[32]) begin
      s.ovf = 1'b1;
      s.val = l.neg ? MinNeg : MaxPos;
    end else if (l.neg) begin
      if (l.q[31:0] > MinNeg) begin
        s.ovf = 1'b1;
        s.val = MinNeg;
      end else begin
        s.val = -l.q[31:0];
      end
    end else if (l.q[31]) begin
      s.ovf = 1'b1;
      s.val = MaxPos;
    end
    return s;
  endfunction

  function automatic sat_t sat_sig(logic signed [64:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > SatHi) begin
      s.ovf = 1'b1;
      s.val = MaxPos;
    end else if (v < SatLo) begin
      s.ovf = 1'b1;
      s.val = MinNeg;
    end
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_item_q <= pop_data_i;
      p_rr_q   <= pop_data_i.a_re * pop_data_i.b_re;
      p_ii_q   <= pop_data_i.a_im * pop_data_i.b_im;
      p_ri_q   <= pop_data_i.a_re * pop_data_i.b_im;
      p_ir_q   <= pop_data_i.a_im * pop_data_i.b_re;
      sq_r_q   <= pop_data_i.b_re * pop_data_i.b_re;
      sq_i_q   <= pop_data_i.b_im * pop_data_i.b_im;
    end
  end

  always_comb begin
    logic signed [64:0] mul_re, mul_im, num_re, num_im;
    mul_re = 65'(p_rr_q) - 65'(p_ii_q);
    mul_im = 65'(p_ri_q) + 65'(p_ir_q);
    num_re = 65'(p_rr_q) + 65'(p_ii_q);
    num_im = 65'(p_ir_q) - 65'(p_ri_q);
    c_d.is_div = (m_item_q.op == OP_DIV);
    c_d.dz     = m_item_q.dz;
    c_d.den    = 64'(sq_r_q) + 64'(sq_i_q);
    c_d.re     = lane_init(num_re);
    c_d.im     = lane_init(num_im);
    case (m_item_q.op)
      OP_ADD: begin
        c_d.alt_re = 65'(m_item_q.a_re) + 65'(m_item_q.b_re);
        c_d.alt_im = 65'(m_item_q.a_im) + 65'(m_item_q.b_im);
      end
      OP_SUB: begin
        c_d.alt_re = 65'(m_item_q.a_re) - 65'(m_item_q.b_re);
        c_d.alt_im = 65'(m_item_q.a_im) - 65'(m_item_q.b_im);
      end
      OP_MUL: begin
        // arithmetic shift rounds toward minus infinity
        c_d.alt_re = mul_re >>> FracBits;
        c_d.alt_im = mul_im >>> FracBits;
      end
      default: begin
        c_d.alt_re = '0;
        c_d.alt_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= c_d;
      for (int k = 0; k < DivSteps; k++) begin
        st_q[k+1] <= stage_step(st_q[k]);
      end
    end
  end

  always_comb begin
    sat_t s_re, s_im;
    if (st_q[DivSteps].is_div) begin
      s_re = sat_div(st_q[DivSteps].re);
      s_im = sat_div(st_q[DivSteps].im);
    end else begin
      s_re = sat_sig(st_q[DivSteps].alt_re);
      s_im = sat_sig(st_q[DivSteps].alt_im);
    end
    if (st_q[DivSteps].dz) begin
      out_d.res_re   = '0;
      out_d.res_im   = '0;
      out_d.div_zero = 1'b1;
      out_d.overflow = 1'b0;
    end else begin
      out_d.res_re   = s_re.val;
      out_d.res_im   = s_im.val;
      out_d.div_zero = 1'b0;
      out_d.overflow = s_re.ovf | s_im.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      st_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q   <= pop_o;
      st_valid_q  <= {st_valid_q[DivSteps-1:0], m_valid_q};
      out_valid_q <= st_valid_q[DivSteps];
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.div_zero |->
      out_q.res_re == '0 && out_q.res_im == '0 && !out_q.overflow)
    else $error("zero divisor result not cleared");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow |->
      (out_q.res_re == MaxPos || out_q.res_re == MinNeg ||
       out_q.res_im == MaxPos || out_q.res_im == MinNeg))
    else $error("overflow without a saturated part");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && m_valid_q |=> st_valid_q[0])
    else $error("item lost between multiply and combine");
`endif

endmodule

[rtl/complex_arithmetic_unit.sv]
// complex_arithmetic_unit: top level of the complex add/sub/mul/div unit
// depends on cau_pkg, cau_front, cau_queue and cau_back
//
// Takes one item per cycle while in_stall_o is low and returns one result per
// item, in order. An item passes through the input register, the queue, the
// multipliers, the combine stage, the restoring divider pipeline that every
// operation passes through, and the output register. Operands are Q16.16.
// Throughput stays at one per cycle while the output side takes results.

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cau_out_t out_data_o
);

  logic       push, pop;
  cau_item_t  push_data, pop_data;
  cau_qstat_t qstat;

  cau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .qstat_i     (qstat)
  );

  cau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
